// ===== hdl/rdwr_pkg.sv =====
// Shared types and constants for the random draw without replacement block.
// Holds the controller/datapath command and status structs and register codes.
// No dependencies.
`timescale 1ns / 1ps

package rdwr_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register index codes (paddr[2] selects the word)
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  // Result status codes
  localparam logic ST_DRAWN = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef struct packed {
    logic latch_word;   // capture random word of accepted item
    logic start_draw;   // read attempt entry, arm shift pointer
    logic load_result;  // load output register
    logic shift_step;   // one step of the shift-down pipeline
    logic finish;       // retire draw: count down, advance written mark
  } cmd_t;

  typedef struct packed {
    logic pool_empty;
    logic reject;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/rdwr_ctrl.sv =====
// Controller state machine for the random draw block.
// Sequences check, result hand-off and shift-down; depends on rdwr_pkg.
`timescale 1ns / 1ps

module rdwr_ctrl
  import rdwr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    CHECK,
    EMIT,
    SHIFT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.latch_word = 1'b1;
          state_next     = CHECK;
        end
      end
      CHECK: begin
        if (sts.pool_empty) begin
          state_next = EMIT;
        end else if (sts.reject) begin
          state_next = IDLE;
        end else begin
          cmd.start_draw = 1'b1;
          state_next     = EMIT;
        end
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = sts.pool_empty ? IDLE : SHIFT;
        end
      end
      SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != IDLE);

endmodule

// ===== hdl/rdwr_dp.sv =====
// Datapath for the random draw block: range registers, pool memory,
// attempt extraction, shift pipeline and output register. Depends on rdwr_pkg.
`timescale 1ns / 1ps

module rdwr_dp
  import rdwr_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  // config port
  input  logic                     cfg_we,
  input  logic                     cfg_sel,
  input  logic [DATA_W-1:0]        cfg_wdata,
  output logic [DATA_W-1:0]        cfg_rdata,
  // input payload
  input  logic [DATA_W-1:0]        random_word,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] drawn_value,
  output logic                     status,
  // control
  input  cmd_t                     cmd,
  output sts_t                     sts
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = (CW > 0) ? $clog2(CW + 1) : 1;
  localparam int RST_SPAN = 1024;
  localparam logic [CW-1:0] RST_COUNT =
    (RST_SPAN > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(RST_SPAN);

  logic [DATA_W-1:0] range_low;
  logic [DATA_W-1:0] range_high;
  logic [CW-1:0]     pool_count;
  logic [CW-1:0]     mark;       // entries below mark still hold their index
  logic [DATA_W-1:0] word_q;
  logic [CW-1:0]     rd_ptr;
  logic [CW-1:0]     rd_addr_q;
  logic              pend;
  logic [AW-1:0]     rdata_raw;
  logic [AW-1:0]     mem [MAX_ENTRIES];

  // ---- refill count from the prospective range ----
  logic [DATA_W-1:0] lo_new;
  logic [DATA_W-1:0] hi_new;
  logic [33:0]       diff;
  logic [CW-1:0]     refill_count;

  always_comb begin
    lo_new = (cfg_sel == REG_RANGE_LOW)  ? cfg_wdata : range_low;
    hi_new = (cfg_sel == REG_RANGE_HIGH) ? cfg_wdata : range_high;
    diff   = {{2{hi_new[31]}}, hi_new} - {{2{lo_new[31]}}, lo_new};
    if (diff[33]) begin
      refill_count = '0;
    end else if (diff >= 34'(MAX_ENTRIES)) begin
      refill_count = CW'(MAX_ENTRIES);
    end else begin
      refill_count = CW'(diff) + CW'(1);
    end
  end

  // ---- attempt: top n bits, n least with count <= 2^n ----
  logic [NW-1:0]     n;
  logic [DATA_W-1:0] attempt_full;
  logic [AW-1:0]     attempt;

  always_comb begin
    n = NW'(CW);
    for (int k = CW; k >= 0; k--) begin
      if (((CW+1)'(1) << k) >= {1'b0, pool_count}) begin
        n = NW'(k);
      end
    end
    if (n == '0) begin
      attempt_full = '0;
    end else begin
      attempt_full = word_q >> (6'(DATA_W) - 6'(n));
    end
    attempt = attempt_full[AW-1:0];
  end

  // ---- memory access ----
  logic          shift_rd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] offset;

  assign shift_rd = cmd.shift_step && (rd_ptr < pool_count);
  assign rd_en    = cmd.start_draw || shift_rd;
  assign rd_addr  = cmd.start_draw ? attempt : rd_ptr[AW-1:0];
  assign offset   = (rd_addr_q < mark) ? rd_addr_q[AW-1:0] : rdata_raw;
  assign wr_en    = cmd.shift_step && pend;
  assign wr_addr  = rd_addr_q[AW-1:0] - AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= offset;
    end
    if (rd_en) begin
      rdata_raw <= mem[rd_addr];
      rd_addr_q <= CW'(rd_addr);
    end
  end

  // ---- pool control state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= DATA_W'(RST_SPAN - 1);
      pool_count <= RST_COUNT;
      mark       <= CW'(MAX_ENTRIES);
      rd_ptr     <= '0;
      pend       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == REG_RANGE_LOW) begin
          range_low <= cfg_wdata;
        end else begin
          range_high <= cfg_wdata;
        end
        pool_count <= refill_count;
        mark       <= CW'(MAX_ENTRIES);
      end else if (cmd.finish) begin
        // the shift rewrote every live entry from the drawn position up
        pool_count <= pool_count - CW'(1);
        mark       <= (CW'(attempt) < mark) ? CW'(attempt) : mark;
      end
      if (cmd.start_draw) begin
        rd_ptr <= CW'(attempt) + CW'(1);
        pend   <= 1'b0;
      end else if (cmd.shift_step) begin
        pend <= shift_rd;
        if (shift_rd) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_word) begin
      word_q <= random_word;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      if (sts.pool_empty) begin
        drawn_value <= '0;
        status      <= ST_EMPTY;
      end else begin
        drawn_value <= $signed(range_low + DATA_W'(offset));
        status      <= ST_DRAWN;
      end
    end
  end

  assign cfg_rdata = (cfg_sel == REG_RANGE_HIGH) ? range_high : range_low;

  assign sts.pool_empty = (pool_count == '0);
  assign sts.reject     = (attempt_full >= DATA_W'(pool_count));
  assign sts.shift_done = !(rd_ptr < pool_count) && !pend;
  assign sts.out_free   = !out_valid || !out_stall;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pool_count <= CW'(MAX_ENTRIES))
    else $error("pool count above capacity");

  a_write_in_pool: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < pool_count - CW'(1)))
    else $error("shift write outside live pool");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> sts.out_free)
    else $error("result loaded over a pending item");

  a_finish_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && !cfg_we |=> pool_count == $past(pool_count) - CW'(1))
    else $error("finished draw did not retire one entry");

endmodule

// ===== hdl/random_draw_without_replacement.sv =====
// Random draw without replacement: top level joining controller and datapath.
// Depends on rdwr_pkg, rdwr_ctrl and rdwr_dp.
//
// Usage:
//   The pool holds the integers range_low..range_high (clamped to MAX_ENTRIES
//   values, empty when high < low), stored in ascending order.
//   Input channel (in_valid/in_stall/random_word): each item brings a 32-bit
//   random word; its top n bits (n least with count <= 2^n) pick a position.
//   Output channel (out_valid/out_stall/drawn_value/status): a hit yields the
//   value and removes it; an empty pool yields status 1, drawn_value 0;
//   a pick at or past the count is rejected and yields no item.
//   Sequence: an accepted item passes the CHECK state, and its result is
//   registered in the EMIT state once the output slot is free.
//   Throughput: one item at a time. After a draw at position a the later
//   count-1-a entries shift down through the pool memory (one read and one
//   write port), one entry per cycle, and the next item is accepted only
//   after that shift. A rejected pick and an empty-pool item skip the shift.
//   Stall: while out_stall holds a result, the shift still runs and the next
//   item is checked; its result waits in the controller until the slot frees.
//   Reset: synchronous; range 0..1023, pool full in order. Writing either
//   range register refills the pool at once (no clearing pass: entries never
//   rewritten since the refill read back as their own index).
//   Config: APB, pready always high, range_low at 0x0, range_high at 0x4.
`timescale 1ns / 1ps

module random_draw_without_replacement
  import rdwr_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  // APB config
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  // input item
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DATA_W-1:0]        random_word,
  // result item
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] drawn_value,
  output logic                     status
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  // write lands in the access phase; paddr[2] picks the word
  assign cfg_we = psel && penable && pwrite && pready;

  rdwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdwr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_sel     (paddr[2]),
    .cfg_wdata   (pwdata),
    .cfg_rdata   (prdata),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drawn_value (drawn_value),
    .status      (status),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Items are only taken while idle, so nothing enters mid-shift.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> in_stall)
    else $error("input taken during shift");

  a_result_needs_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !cmd.latch_word && in_stall)
    else $error("result loaded while accepting");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

endmodule

// ===== tb/sv/rdwr_tb_pkg.sv =====
// Scoreboard for the random draw without replacement testbench.
// Holds a shadow copy of the pool and the queue of expected draws.
// Depends on rdwr_pkg.
`timescale 1ns / 1ps

package rdwr_tb_pkg;
  import rdwr_pkg::*;

  localparam int POOL_DEPTH = 1024;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     status;
  } draw_t;

  class draw_scoreboard;
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;
    logic [9:0]               offsets [POOL_DEPTH];
    int unsigned              pool_count;
    draw_t                    expected_draws [$];
    int                       mismatches;

    function new();
      mismatches = 0;
      reset_pool();
    endfunction

    // ascending offsets, count clamped to the pool depth
    function void refill();
      longint span;
      if (range_high < range_low) span = 0;
      else span = longint'(range_high) - longint'(range_low) + 1;
      if (span > POOL_DEPTH) span = POOL_DEPTH;
      pool_count = int'(span);
      for (int i = 0; i < POOL_DEPTH; i++) offsets[i] = 10'(i);
    endfunction

    function void reset_pool();
      range_low  = 0;
      range_high = 1023;
      refill();
    endfunction

    function void write_range(logic sel, logic [DATA_W-1:0] value);
      if (sel == REG_RANGE_LOW) range_low = value;
      else range_high = value;
      refill();
    endfunction

    // least n with count <= 2^n
    function int unsigned pick_width();
      int unsigned n;
      longint      span;
      n = 0;
      span = 1;
      while (longint'(pool_count) > span) begin
        span = span << 1;
        n++;
      end
      return n;
    endfunction

    // accepted word: queue the draw it causes, if any, and update the pool
    function void note_word(logic [DATA_W-1:0] word);
      int unsigned n;
      int unsigned pos;
      draw_t       d;
      if (pool_count == 0) begin
        d.value  = 0;
        d.status = ST_EMPTY;
        expected_draws.push_back(d);
        return;
      end
      n = pick_width();
      pos = (n == 0) ? 0 : int'(word >> (DATA_W - n));
      if (pos >= pool_count) return;   // rejected, nothing comes out
      d.value  = range_low + {22'b0, offsets[pos]};
      d.status = ST_DRAWN;
      expected_draws.push_back(d);
      for (int unsigned i = pos; i + 1 < pool_count; i++) offsets[i] = offsets[i + 1];
      pool_count--;
    endfunction

    function void flag(string field, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_draw(logic signed [DATA_W-1:0] value, logic status);
      draw_t want;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result, value %0d status %0d", $time, value, status);
        return;
      end
      want = expected_draws.pop_front();
      if (status !== want.status) flag("status", int'(want.status), int'(status));
      if (value !== want.value) flag("drawn_value", int'(want.value), int'(value));
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for random_draw_without_replacement.
// Drives random words and range writes, checks every draw against a shadow pool.
// Depends on rdwr_pkg, rdwr_tb_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import rdwr_pkg::*;
  import rdwr_tb_pkg::*;

  // A draw shifts up to POOL_DEPTH - 1 entries after its result is out, so an idle
  // check waits that long after the last expected result.
  localparam int SETTLE_CYCLES = POOL_DEPTH + 16;
  // Watchdog bound: at most 647 items, each at worst followed by a full-pool shift,
  // plus the long receiver hold, sender gaps and per-phase settles.
  localparam int RUN_LIMIT     = 4_000_000;
  localparam int RANDOM_ITEMS  = 560;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_stall;
  logic [DATA_W-1:0]        random_word;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] drawn_value;
  logic                     status;

  draw_scoreboard sb;

  // sender shaping
  bit gaps_on;
  int burst_left;
  // one-shot request for the long receiver hold
  bit hold_request;
  bit hold_done;

  random_draw_without_replacement dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drawn_value (drawn_value),
    .status      (status)
  );

  always #1 clk = ~clk;

  // Result side: every result taken from the output goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_draw(drawn_value, status);
  end

  // Receiver stall pattern. Modes are picked at random in turn: no stall,
  // light stall, heavy stall, with an occasional medium hold. The long hold
  // is counted here so the sender keeps pushing and the block backs up.
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    out_stall = 1'b0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 128);
        if ($urandom_range(0, 11) == 0 && hold_left == 0) hold_left = $urandom_range(80, 250);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 4) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 6);
        endcase
      end
    end
  end

  // Watchdog: cycle count since time zero.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one item, holding it until accepted. In bursty mode a random gap
  // (now and then a long one) comes before each new burst.
  task automatic send_word(input logic [DATA_W-1:0] word);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    random_word <= word;
    do @(posedge clk); while (in_stall);
    sb.note_word(word);
    if (burst_left > 0) burst_left--;
  endtask

  // APB write: setup then access; the register takes it at the access edge.
  task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_range(sel, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Idle point: input dropped, all draws back, then room for a trailing
  // shift or a rejected pick still in flight.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_range(input logic [DATA_W-1:0] low, input logic [DATA_W-1:0] high);
    settle();
    write_reg(REG_RANGE_LOW, low);
    write_reg(REG_RANGE_HIGH, high);
  endtask

  // Mostly a pick inside the current pool so draws dominate; the rest are
  // raw words, which also exercise the reject path.
  function automatic logic [DATA_W-1:0] biased_word();
    int unsigned       n;
    logic [DATA_W-1:0] pos;
    n = sb.pick_width();
    if (n == 0 || $urandom_range(0, 9) < 3) return $urandom();
    pos = $urandom_range(0, sb.pool_count - 1);
    return (pos << (DATA_W - n)) | ($urandom() >> n);
  endfunction

  // One random phase: pick a range, refill, then draw from it. Small pools
  // dominate since every draw from a big one costs a long shift.
  task automatic run_random_phase(output int sent);
    int                pick;
    int                size;
    int                items;
    longint            top;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    pick = $urandom_range(0, 99);
    low  = $urandom();
    high = $urandom();
    if (pick < 90) begin
      if (pick < 70) size = $urandom_range(1, 48);
      else if (pick < 85) size = $urandom_range(49, 256);
      else size = $urandom_range(POOL_DEPTH, 4 * POOL_DEPTH);
      if ($urandom_range(0, 9) == 0) low = 32'h8000_0000;
      top  = longint'($signed(low)) + size - 1;
      high = (top > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : top[31:0];
    end else if (pick < 95) begin
      // inverted: high strictly below low
      a = $urandom();
      b = $urandom();
      if (a == b) b = a ^ 32'h1;
      if ($signed(a) > $signed(b)) begin
        low  = a;
        high = b;
      end else begin
        low  = b;
        high = a;
      end
    end
    set_range(low, high);
    if (sb.pool_count == 0) items = $urandom_range(2, 5);
    else if (sb.pool_count > 256) items = $urandom_range(4, 12);
    else begin
      items = 2 * sb.pool_count + $urandom_range(0, 6);
      if (items > 70) items = 70;
    end
    gaps_on    = ($urandom_range(0, 3) != 0);
    burst_left = 0;
    if (!hold_done && items >= 20) begin
      hold_request = 1'b1;
      hold_done    = 1'b1;
    end
    for (int k = 0; k < items; k++) send_word(biased_word());
    sent = items;
  endtask

  initial begin
    int random_sent;
    int sent;
    sb           = new();
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    random_word  = '0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    random_sent  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset pool 0..1023: first position, then two picks at the top of the
    // shrunken count (rejected) and a low one.
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFC0_0000);
    send_word(32'h0040_0000);

    // Single entry at the top of the signed range, then empty.
    set_range(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);

    // Single entry at the bottom of the signed range, then empty.
    set_range(32'h8000_0000, 32'h8000_0000);
    send_word(32'h1234_5678);
    send_word(32'h0000_0000);

    // Inverted range: every item reports an empty pool.
    set_range(32'd5, 32'd4);
    send_word(32'hA5A5_A5A5);
    send_word(32'h5A5A_5A5A);

    // Full signed span, clamped to the pool depth.
    set_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);

    // Three entries across zero: reject, middle, first, last, then empty.
    set_range(32'hFFFF_FFFF, 32'h0000_0001);
    send_word(32'hC000_0000);
    send_word(32'h4000_0000);
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(32'h8000_0000);

    // Exact power-of-two count: the top pick is legal.
    set_range(32'd0, 32'd3);
    send_word(32'hFFFF_FFFF);

    while (random_sent < RANDOM_ITEMS) begin
      run_random_phase(sent);
      random_sent += sent;
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rdwr_pkg.sv
hdl/rdwr_ctrl.sv
hdl/rdwr_dp.sv
hdl/random_draw_without_replacement.sv
tb/sv/rdwr_tb_pkg.sv
tb/sv/testbench.sv
